@@ rtl/rle_pkg.sv @@
// Shared constants, types and helpers for the run-length byte compressor.
`default_nettype none
package rle_pkg;

	localparam int SEQ_LEN          = 128;
	localparam int BYTES_PER_RESULT = 8;

	localparam int ROWS     = (SEQ_LEN + BYTES_PER_RESULT - 1) / BYTES_PER_RESULT;
	localparam int ROW_AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int COL_W    = (BYTES_PER_RESULT > 1) ? $clog2(BYTES_PER_RESULT) : 1;
	localparam int LEN_W    = $clog2(SEQ_LEN + 1);
	localparam int ROW_BITS = BYTES_PER_RESULT * 8;
	localparam int CNT_W    = 4;
	localparam int PAY_W    = 64;

	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

	// Codes carried on the action field of an input word.
	localparam logic ACT_BYTE  = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;

	typedef enum logic [1:0] {
		CMD_SINGLE,
		CMD_REPEAT,
		CMD_LIT
	} cmd_kind_t;

	// One closed block, handed from the front to the back.
	typedef struct packed {
		cmd_kind_t        kind;
		logic [7:0]       header;
		logic [LEN_W-1:0] len;
		logic [7:0]       value;
		logic             bank;
	} blk_cmd_t;

	// One byte write into the literal store.
	typedef struct packed {
		logic              en;
		logic              bank;
		logic [ROW_AW-1:0] row;
		logic [COL_W-1:0]  col;
		logic [7:0]        value;
	} mem_wr_t;

	// The back hands a drained literal bank back to the front.
	typedef struct packed {
		logic en;
		logic bank;
	} bank_rel_t;

	function automatic logic [ROW_BITS-1:0] byte_mask(input logic [CNT_W-1:0] cnt);
		logic [ROW_BITS-1:0] m;
		m = '0;
		for (int i = 0; i < BYTES_PER_RESULT; i++) begin
			m[i*8 +: 8] = (CNT_W'(i) < cnt) ? 8'hFF : 8'h00;
		end
		return m;
	endfunction

endpackage
`default_nettype wire

@@ rtl/rle_front.sv @@
// Front end: accepts words, tracks the open block and closes blocks into the queue.
`default_nettype none
module rle_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	output logic                     item_ready,
	input  wire logic                action,
	input  wire logic [7:0]          data_byte,
	output logic                     push_en,
	output rle_pkg::blk_cmd_t        push_cmd,
	input  wire logic                q_full,
	output rle_pkg::mem_wr_t         wr,
	input  wire rle_pkg::bank_rel_t  rel
);
	import rle_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SINGLE,
		ST_REPEAT,
		ST_LIT
	} state_t;

	state_t            state_q;
	logic [LEN_W-1:0]  cnt_q;
	logic [7:0]        first_q;
	logic [7:0]        last_q;
	logic [ROW_AW-1:0] row_q;
	logic [COL_W-1:0]  col_q;
	logic              bank_q;
	logic [1:0]        busy_q;

	logic              same_first;
	logic              same_last;
	logic              close_rep;
	logic              close_lit;
	logic              need_push;
	logic              start_lit;
	logic              accept;
	logic [ROW_AW-1:0] nxt_row;
	logic [COL_W-1:0]  nxt_col;
	logic [1:0]        busy_set;
	logic [1:0]        busy_clr;

	assign same_first = (data_byte == first_q);
	assign same_last  = (data_byte == last_q);
	assign close_rep  = (state_q == ST_REPEAT) &&
		((cnt_q >= LEN_W'(SEQ_LEN - 1)) || !same_first);
	assign close_lit  = (state_q == ST_LIT) &&
		((cnt_q >= LEN_W'(SEQ_LEN)) || same_last);
	assign need_push  = action ? (state_q != ST_IDLE) : (close_rep || close_lit);
	assign start_lit  = !action && (state_q == ST_SINGLE) && !same_first;

	// A new literal needs its bank drained; a closing block needs queue room.
	assign item_ready = !(need_push && q_full) && !(start_lit && busy_q[bank_q]);
	assign accept     = item_valid && item_ready;
	assign push_en    = accept && need_push;

	always_comb begin
		push_cmd.value = first_q;
		push_cmd.bank  = bank_q;
		unique case (state_q)
			ST_REPEAT: begin
				push_cmd.kind   = CMD_REPEAT;
				push_cmd.header = 8'(cnt_q);
				push_cmd.len    = LEN_W'(1);
			end
			ST_LIT: begin
				push_cmd.kind   = CMD_LIT;
				push_cmd.header = 8'(0) - 8'(cnt_q);
				push_cmd.len    = cnt_q;
			end
			default: begin
				push_cmd.kind   = CMD_SINGLE;
				push_cmd.header = 8'(0);
				push_cmd.len    = LEN_W'(1);
			end
		endcase
	end

	// The newest literal byte sits in last_q and is written one word later,
	// so that every word writes at most one byte.
	always_comb begin
		wr.en    = accept && (start_lit || (state_q == ST_LIT));
		wr.bank  = bank_q;
		wr.row   = start_lit ? '0 : row_q;
		wr.col   = start_lit ? '0 : col_q;
		wr.value = start_lit ? first_q : last_q;
	end

	always_comb begin
		if (wr.col == COL_W'(BYTES_PER_RESULT - 1)) begin
			nxt_row = wr.row + ROW_AW'(1);
			nxt_col = '0;
		end else begin
			nxt_row = wr.row;
			nxt_col = wr.col + COL_W'(1);
		end
	end

	always_comb begin
		busy_set = '0;
		busy_clr = '0;
		if (push_en && (state_q == ST_LIT)) begin
			busy_set[bank_q] = 1'b1;
		end
		if (rel.en) begin
			busy_clr[rel.bank] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bank_q  <= 1'b0;
			busy_q  <= '0;
			cnt_q   <= '0;
		end else begin
			busy_q <= (busy_q | busy_set) & ~busy_clr;
			if (accept) begin
				if (action) begin
					state_q <= ST_IDLE;
					if (state_q == ST_LIT) begin
						bank_q <= ~bank_q;
					end
				end else begin
					unique case (state_q)
						ST_IDLE: begin
							first_q <= data_byte;
							state_q <= ST_SINGLE;
						end
						ST_SINGLE: begin
							cnt_q <= LEN_W'(2);
							if (same_first) begin
								state_q <= ST_REPEAT;
							end else begin
								state_q <= ST_LIT;
								last_q  <= data_byte;
								row_q   <= nxt_row;
								col_q   <= nxt_col;
							end
						end
						ST_REPEAT: begin
							if (close_rep) begin
								first_q <= data_byte;
								state_q <= ST_SINGLE;
							end else begin
								cnt_q <= cnt_q + LEN_W'(1);
							end
						end
						ST_LIT: begin
							if (close_lit) begin
								first_q <= data_byte;
								state_q <= ST_SINGLE;
								bank_q  <= ~bank_q;
							end else begin
								last_q <= data_byte;
								cnt_q  <= cnt_q + LEN_W'(1);
								row_q  <= nxt_row;
								col_q  <= nxt_col;
							end
						end
						default: begin
							state_q <= ST_IDLE;
						end
					endcase
				end
			end
		end
	end

	a_wr_free_bank: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> !busy_q[wr.bank])
		else $error("literal byte written into a bank still waiting to drain");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push_en |-> !q_full)
		else $error("block pushed into a full queue");

	a_rel_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rel.en |-> busy_q[rel.bank])
		else $error("bank released that was not pending");

	a_fill_bank: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LIT) |-> !busy_q[bank_q])
		else $error("open literal run sits in a bank still pending");

endmodule
`default_nettype wire

@@ rtl/rle_cmd_fifo.sv @@
// Short queue of closed blocks between the front and the back.
`default_nettype none
module rle_cmd_fifo (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire rle_pkg::blk_cmd_t  push_cmd,
	input  wire logic               pop,
	output rle_pkg::blk_cmd_t       head,
	output logic                    empty,
	output logic                    full
);
	import rle_pkg::*;

	blk_cmd_t           slot_q [CMDQ_DEPTH];
	logic [CMDQ_AW:0]   wr_ptr_q;
	logic [CMDQ_AW:0]   rd_ptr_q;

	assign empty = (wr_ptr_q == rd_ptr_q);
	assign full  = (wr_ptr_q[CMDQ_AW] != rd_ptr_q[CMDQ_AW]) &&
		(wr_ptr_q[CMDQ_AW-1:0] == rd_ptr_q[CMDQ_AW-1:0]);
	assign head  = slot_q[rd_ptr_q[CMDQ_AW-1:0]];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q[CMDQ_AW-1:0]] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + (CMDQ_AW + 1)'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + (CMDQ_AW + 1)'(1);
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/rle_back.sv @@
// Back end: literal store, block sequencer and output register.
`default_nettype none
module rle_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire rle_pkg::blk_cmd_t            cmd,
	input  wire logic                         q_empty,
	output logic                              pop,
	output rle_pkg::bank_rel_t                rel,
	input  wire rle_pkg::mem_wr_t             wr,
	output logic                              res_valid,
	input  wire logic                         res_ready,
	output logic                              header_valid,
	output logic signed [7:0]                 header,
	output logic [rle_pkg::CNT_W-1:0]         byte_count,
	output logic [rle_pkg::PAY_W-1:0]         payload,
	output logic                              block_end
);
	import rle_pkg::*;

	localparam int MEM_AW    = ROW_AW + 1;
	localparam int MEM_DEPTH = 1 << MEM_AW;

	logic [ROW_BITS-1:0] mem_q [MEM_DEPTH];

	logic [ROW_AW-1:0]   row_q;
	logic [LEN_W-1:0]    rem_q;

	logic                valid_s1;
	logic                hv_s1;
	logic [7:0]          hdr_s1;
	logic [CNT_W-1:0]    cnt_s1;
	logic                lit_s1;
	logic [7:0]          val_s1;
	logic                end_s1;
	logic [ROW_BITS-1:0] rd_data_s1;

	logic                valid_s2;
	logic                hv_s2;
	logic [7:0]          hdr_s2;
	logic [CNT_W-1:0]    cnt_s2;
	logic [PAY_W-1:0]    pay_s2;
	logic                end_s2;

	logic                starting;
	logic                lit;
	logic [LEN_W-1:0]    rem_cur;
	logic                last_piece;
	logic [CNT_W-1:0]    take;
	logic                adv_s1;
	logic                free_s1;
	logic                issue;
	logic                rd_en;
	logic [MEM_AW-1:0]   rd_addr;

	assign starting   = (row_q == '0);
	assign lit        = (cmd.kind == CMD_LIT);
	assign rem_cur    = starting ? cmd.len : rem_q;
	assign last_piece = !lit || (rem_cur <= LEN_W'(BYTES_PER_RESULT));
	assign take       = !lit ? CNT_W'(1) :
		(last_piece ? CNT_W'(rem_cur) : CNT_W'(BYTES_PER_RESULT));

	assign adv_s1  = valid_s1 && (!valid_s2 || res_ready);
	assign free_s1 = !valid_s1 || adv_s1;
	assign issue   = !q_empty && free_s1;
	assign rd_en   = issue && lit;
	assign rd_addr = {cmd.bank, row_q};
	assign pop     = issue && last_piece;

	always_comb begin
		rel.en   = pop && lit;
		rel.bank = cmd.bank;
	end

	// The read register only moves on a new read, so it holds the stage 1
	// data for as long as stage 1 is stalled.
	always_ff @(posedge clk) begin
		for (int i = 0; i < BYTES_PER_RESULT; i++) begin
			if (wr.en && (wr.col == COL_W'(i))) begin
				mem_q[{wr.bank, wr.row}][i*8 +: 8] <= wr.value;
			end
		end
		if (rd_en) begin
			rd_data_s1 <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '0;
			rem_q    <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (issue) begin
				if (last_piece) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + ROW_AW'(1);
					rem_q <= rem_cur - LEN_W'(BYTES_PER_RESULT);
				end
			end
			if (free_s1) begin
				valid_s1 <= issue;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (res_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			hv_s1  <= starting;
			hdr_s1 <= cmd.header;
			cnt_s1 <= take;
			lit_s1 <= lit;
			val_s1 <= cmd.value;
			end_s1 <= last_piece;
		end
		if (adv_s1) begin
			hv_s2  <= hv_s1;
			hdr_s2 <= hv_s1 ? hdr_s1 : 8'(0);
			cnt_s2 <= cnt_s1;
			pay_s2 <= lit_s1 ? PAY_W'(rd_data_s1 & byte_mask(cnt_s1)) : PAY_W'(val_s1);
			end_s2 <= end_s1;
		end
	end

	assign res_valid    = valid_s2;
	assign header_valid = hv_s2;
	assign header       = $signed(hdr_s2);
	assign byte_count   = cnt_s2;
	assign payload      = pay_s2;
	assign block_end    = end_s2;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (cnt_s1 != '0) && (cnt_s1 <= CNT_W'(BYTES_PER_RESULT)))
		else $error("result byte count out of range");

	a_short_block: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !lit_s1) |-> (cnt_s1 == CNT_W'(1)) && end_s1 && hv_s1)
		else $error("single or repeat block spread over several results");

endmodule
`default_nettype wire

@@ rtl/rle_byte_compressor_top.sv @@
// Top level of the run-length byte compressor.
//
//  channel   signals                                           word
//  -------   -----------------------------------------------   -----------------------
//  item      item_valid, item_ready, action, data_byte         one byte or end of stream
//  result    res_valid, res_ready, header_valid, header,       one piece of a block
//            byte_count, payload, block_end
//
// The front takes one word per cycle; a block closes into a four-entry queue.
// A result passes the queue, stage 1 and the output register; a literal block
// of n bytes drains at one result per cycle while res_ready is high, in
// ceil(n/8) results, from one read port of a two-bank literal store, so the
// next block fills meanwhile. The front stalls when a closing block finds the
// queue full, or when a new literal run finds its bank still waiting to drain.
// Reset clears all control state at once; the store needs no clearing pass.
`default_nettype none
module rle_byte_compressor_top (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      item_valid,
	output logic                           item_ready,
	input  wire logic                      action,
	input  wire logic [7:0]                data_byte,
	output logic                           res_valid,
	input  wire logic                      res_ready,
	output logic                           header_valid,
	output logic signed [7:0]              header,
	output logic [rle_pkg::CNT_W-1:0]      byte_count,
	output logic [rle_pkg::PAY_W-1:0]      payload,
	output logic                           block_end
);
	import rle_pkg::*;

	logic      push_en;
	blk_cmd_t  push_cmd;
	blk_cmd_t  head;
	logic      q_empty;
	logic      q_full;
	logic      pop;
	mem_wr_t   wr;
	bank_rel_t rel;

	rle_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.action     (action),
		.data_byte  (data_byte),
		.push_en    (push_en),
		.push_cmd   (push_cmd),
		.q_full     (q_full),
		.wr         (wr),
		.rel        (rel)
	);

	rle_cmd_fifo u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push_en),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty),
		.full     (q_full)
	);

	rle_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (head),
		.q_empty      (q_empty),
		.pop          (pop),
		.rel          (rel),
		.wr           (wr),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.header_valid (header_valid),
		.header       (header),
		.byte_count   (byte_count),
		.payload      (payload),
		.block_end    (block_end)
	);

endmodule
`default_nettype wire

@@ tb/rle_block_checker.sv @@
// Checker for the run-length byte compressor: predicts every result word and compares.
`timescale 1ns / 1ps
module rle_block_checker (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       item_valid,
	input  wire logic                       item_ready,
	input  wire logic                       action,
	input  wire logic [7:0]                 data_byte,
	input  wire logic                       res_valid,
	input  wire logic                       res_ready,
	input  wire logic                       header_valid,
	input  wire logic signed [7:0]          header,
	input  wire logic [rle_pkg::CNT_W-1:0]  byte_count,
	input  wire logic [rle_pkg::PAY_W-1:0]  payload,
	input  wire logic                       block_end,
	output int                              mismatches,
	output int                              words_pending
);
	import rle_pkg::*;

	typedef struct packed {
		logic              first;
		logic signed [7:0] hdr;
		logic [CNT_W-1:0]  cnt;
		logic [PAY_W-1:0]  bytes;
		logic              last;
	} block_word_t;

	block_word_t  block_word_q[$];
	logic [7:0]   run_bytes [SEQ_LEN];
	int           run_len;     // 0 lone byte or empty, >0 repeat length, <0 literal length
	int           held;        // bytes held for the open block, 0 when idle
	int           err_count = 0;

	initial mismatches = 0;
	initial words_pending = 0;

	task automatic report(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		err_count++;
	endtask

	// Splits the open block into result words of up to BYTES_PER_RESULT bytes.
	task automatic emit_open_block();
		logic signed [7:0] hdr;
		int                len;
		int                pos;
		int                take;
		block_word_t       w;
		if (held == 0) return;
		if (run_len == 0) begin
			hdr = 8'sd0;
			len = 1;
		end else if (run_len > 0) begin
			hdr = 8'(run_len);
			len = 1;
		end else begin
			hdr = 8'(-held);
			len = held;
		end
		pos = 0;
		while (pos < len) begin
			take = len - pos;
			if (take > BYTES_PER_RESULT) take = BYTES_PER_RESULT;
			w.first = (pos == 0);
			w.hdr   = (pos == 0) ? hdr : 8'sd0;
			w.cnt   = CNT_W'(take);
			w.bytes = '0;
			for (int i = 0; i < take; i++) w.bytes[i*8 +: 8] = run_bytes[pos + i];
			pos += take;
			w.last = (pos >= len);
			block_word_q.push_back(w);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		block_word_t w;
		if (!arst_n) begin
			block_word_q.delete();
			run_len = 0;
			held = 0;
			words_pending <= 0;
		end else begin
			if (res_valid && res_ready) begin
				if (block_word_q.size() == 0) begin
					report("result word with nothing expected");
				end else begin
					w = block_word_q.pop_front();
					if (header_valid !== w.first)
						report($sformatf("header_valid got %b expected %b", header_valid, w.first));
					if (header !== w.hdr)
						report($sformatf("header got %0d expected %0d", header, w.hdr));
					if (byte_count !== w.cnt)
						report($sformatf("byte_count got %0d expected %0d", byte_count, w.cnt));
					if (payload !== w.bytes)
						report($sformatf("payload got %h expected %h", payload, w.bytes));
					if (block_end !== w.last)
						report($sformatf("block_end got %b expected %b", block_end, w.last));
				end
			end
			if (item_valid && item_ready) begin
				if (action == ACT_FLUSH) begin
					emit_open_block();
					run_len = 0;
					held = 0;
				end else if (held == 0) begin
					run_bytes[0] = data_byte;
					held = 1;
					run_len = 0;
				end else if (run_len == 0) begin
					// The second byte decides between a repeat and a literal run.
					if (data_byte == run_bytes[0]) begin
						run_len = 2;
					end else begin
						run_bytes[1] = data_byte;
						held = 2;
						run_len = -2;
					end
				end else if ((run_len > 0 && (run_len >= SEQ_LEN - 1 || data_byte != run_bytes[0]))
						|| (run_len < 0 && (held >= SEQ_LEN || data_byte == run_bytes[held-1]))) begin
					// The closing byte is not part of the run; it opens the next block.
					emit_open_block();
					run_bytes[0] = data_byte;
					held = 1;
					run_len = 0;
				end else if (run_len > 0) begin
					run_len++;
				end else begin
					run_bytes[held] = data_byte;
					held++;
					run_len--;
				end
			end
			words_pending <= block_word_q.size();
		end
		mismatches <= err_count;
	end

endmodule

@@ tb/tb_rle_byte_compressor_top.sv @@
// Testbench top for the run-length byte compressor: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module tb_rle_byte_compressor_top;
	import rle_pkg::*;

	localparam int   SHORT_ITEMS = 260;
	localparam int   CYCLE_LIMIT = 400000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 item_valid = 1'b0;
	logic                 item_ready;
	logic                 action = ACT_BYTE;
	logic [7:0]           data_byte = 8'h00;
	logic                 res_valid;
	logic                 res_ready = 1'b0;
	logic                 header_valid;
	logic signed [7:0]    header;
	logic [CNT_W-1:0]     byte_count;
	logic [PAY_W-1:0]     payload;
	logic                 block_end;
	int                   mismatches;
	int                   words_pending;
	int                   cycles = 0;
	logic                 tx_burst = 1'b0;
	logic [7:0]           last_byte = 8'h00;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	rle_byte_compressor_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.action       (action),
		.data_byte    (data_byte),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.header_valid (header_valid),
		.header       (header),
		.byte_count   (byte_count),
		.payload      (payload),
		.block_end    (block_end)
	);

	rle_block_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.action        (action),
		.data_byte     (data_byte),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.header_valid  (header_valid),
		.header        (header),
		.byte_count    (byte_count),
		.payload       (payload),
		.block_end     (block_end),
		.mismatches    (mismatches),
		.words_pending (words_pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("rle_byte_compressor_top regression: fail");
			$finish;
		end
	end

	// Offers one word after a random gap and returns once it is taken; valid stays high.
	task automatic send_word(input logic act, input logic [7:0] b);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		action <= act;
		data_byte <= b;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		if (act == ACT_BYTE) last_byte = b;
	endtask

	// Sends n bytes, each differing from the one before it.
	task automatic send_literal(input int n);
		for (int i = 0; i < n; i++) send_word(ACT_BYTE, last_byte ^ 8'($urandom_range(1, 255)));
	endtask

	// Sends n copies of one random byte.
	task automatic send_repeat(input int n);
		logic [7:0] v;
		v = 8'($urandom);
		for (int i = 0; i < n; i++) send_word(ACT_BYTE, v);
	endtask

	// Receiver: random stalls per word, bursts without stalls, and one long hold-off.
	initial begin
		int got;
		int hold;
		logic rx_burst;
		got = 0;
		rx_burst = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
			hold = rx_burst ? 0 : $urandom_range(0, 16);
			if (got == 50) hold = 400;
			if (hold > 0) begin
				res_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			res_ready <= 1'b1;
			@(posedge clk);
			while (!res_valid) @(posedge clk);
			got++;
		end
	end

	initial begin
		int   short_sent;
		int   n;
		int   kind;
		logic long_lit_done;
		logic long_rep_done;
		logic drained_once;
		short_sent = 0;
		long_lit_done = 1'b0;
		long_rep_done = 1'b0;
		drained_once = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty flush with an ignored byte, lone byte, repeat closed by a
		// differing byte, literal closed by an equal byte, flush right after a flush.
		send_word(ACT_FLUSH, 8'hFF);
		send_word(ACT_BYTE, 8'h00);
		send_word(ACT_FLUSH, 8'h00);
		send_word(ACT_BYTE, 8'hFF);
		send_word(ACT_BYTE, 8'hFF);
		send_word(ACT_BYTE, 8'hFF);
		send_word(ACT_BYTE, 8'h00);
		send_word(ACT_BYTE, 8'h80);
		send_word(ACT_BYTE, 8'h7F);
		send_word(ACT_BYTE, 8'h7F);
		send_word(ACT_BYTE, 8'h7F);
		send_word(ACT_FLUSH, 8'h5A);
		send_word(ACT_FLUSH, 8'hA5);
		send_word(ACT_BYTE, 8'h55);
		send_word(ACT_BYTE, 8'hAA);
		send_word(ACT_BYTE, 8'h55);
		send_word(ACT_BYTE, 8'hAA);
		send_word(ACT_BYTE, 8'h55);
		send_word(ACT_FLUSH, 8'h00);
		send_word(ACT_BYTE, 8'h01);
		send_word(ACT_BYTE, 8'h01);
		send_word(ACT_FLUSH, 8'hFF);
		send_word(ACT_BYTE, 8'hA5);
		send_word(ACT_FLUSH, 8'h00);

		while (short_sent < SHORT_ITEMS) begin
			tx_burst = ($urandom_range(0, 3) == 0);
			if (!long_lit_done && short_sent >= 20) begin
				// A full literal run; the byte after it opens the next block.
				n = $urandom_range(SEQ_LEN, SEQ_LEN + 3);
				send_literal(n);
				short_sent += n;
				long_lit_done = 1'b1;
			end else if (!long_rep_done && short_sent >= 160) begin
				// A repeat at its cap, so the next copy opens a fresh block.
				n = $urandom_range(SEQ_LEN - 1, SEQ_LEN + 2);
				send_repeat(n);
				short_sent += n;
				if ($urandom_range(0, 1) == 0) begin
					send_word(ACT_FLUSH, 8'($urandom));
					short_sent++;
				end
				long_rep_done = 1'b1;
			end else if (!drained_once && short_sent >= 120) begin
				item_valid <= 1'b0;
				@(posedge clk);
				while (words_pending != 0) @(posedge clk);
				drained_once = 1'b1;
			end else begin
				kind = $urandom_range(0, 9);
				if (kind <= 3) begin
					n = $urandom_range(1, 10);
					send_repeat(n);
				end else if (kind <= 7) begin
					n = $urandom_range(1, 20);
					send_literal(n);
				end else if (kind == 8) begin
					n = $urandom_range(1, 6);
					for (int i = 0; i < n; i++) send_word(ACT_BYTE, 8'($urandom_range(0, 3)));
				end else begin
					n = 1;
					send_word(ACT_FLUSH, 8'($urandom));
				end
				short_sent += n;
				if ($urandom_range(0, 5) == 0) begin
					send_word(ACT_FLUSH, 8'($urandom));
					short_sent++;
				end
			end
		end
		send_word(ACT_FLUSH, 8'($urandom));
		item_valid <= 1'b0;

		@(posedge clk);
		while (words_pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && words_pending == 0) begin
			$display("rle_byte_compressor_top regression: pass");
		end else begin
			$display("rle_byte_compressor_top regression: fail");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/rle_pkg.sv
rtl/rle_front.sv
rtl/rle_cmd_fifo.sv
rtl/rle_back.sv
rtl/rle_byte_compressor_top.sv
tb/rle_block_checker.sv
tb/tb_rle_byte_compressor_top.sv
